// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk; ALWAYS and IMPLY are disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge out of reset
`define CKSB_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante at an edge implies cons at the same edge
`define CKSB_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante at an edge implies cons at the next edge
`define CKSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/cksb_pkg.sv =====
// ---------------------------------------------------------------------------
// cksb_pkg
// Shared types and constants of the column Kalman smoother bank.
// ---------------------------------------------------------------------------
package cksb_pkg;

  localparam int COL_W      = 7;
  localparam int ROW_W      = 16;
  localparam int FRAC_W     = 16;
  localparam int HGT_W      = 10;
  localparam int COV_W      = 24;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int QDEPTH     = 4;
  localparam int QAW        = 2;
  localparam int QCW        = 3;
  localparam int DIV_STAGES = 25;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_HEIGHT       = 2'd0,
    CFG_PROCESS_NOISE      = 2'd1,
    CFG_MEASUREMENT_NOISE  = 2'd2,
    CFG_INITIAL_COVARIANCE = 2'd3
  } cksb_cfg_idx_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] z;
  } cksb_item_t;

  typedef struct packed {
    logic [COV_W-1:0] q;
    logic [COV_W-1:0] r;
    logic [COV_W-1:0] p0;
  } cksb_filt_cfg_t;

  typedef struct packed {
    logic       vld;
    cksb_item_t item;
  } cksb_qport_t;

endpackage

// ===== design/column_kalman_smoother_bank.sv =====
// Path: front product register, queue, read stage, divider stages, multiply stage, output register.
// Throughput: one item per cycle while out_stall is low; an item whose column is still in the 28-stage
// filter pipeline waits in the queue until that column's write-back completes.
// The gain divider is pipelined, one quotient bit per stage.
// Reset (rst_n low, synchronous): clears control state, all columns unvisited,
// registers return to defaults; no clearing pass.
// ---------------------------------------------------------------------------
// column_kalman_smoother_bank
// Bank of scalar Kalman filters, one per image column, Q10.6 rows.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module column_kalman_smoother_bank import cksb_pkg::*; #(
  parameter int COLUMN_COUNT = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [COL_W-1:0]     in_column,
  input  logic [FRAC_W-1:0]    in_net_output,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [COL_W-1:0]     out_column_echo,
  output logic [ROW_W-1:0]     out_predicted_row,
  output logic [ROW_W-1:0]     out_corrected_row
);

  logic [HGT_W-1:0] height_r;
  cksb_filt_cfg_t   fcfg_r;
  cksb_qport_t      push, head;
  logic             pop;
  logic [QCW-1:0]   q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r  <= HGT_W'(360);
      fcfg_r.q  <= COV_W'(167772);
      fcfg_r.r  <= COV_W'(21810);
      fcfg_r.p0 <= COV_W'(1677722);
    end else if (cfg_we) begin
      case (cksb_cfg_idx_t'(cfg_index))
        CFG_IMAGE_HEIGHT:       height_r  <= cfg_wdata[HGT_W-1:0];
        CFG_PROCESS_NOISE:      fcfg_r.q  <= cfg_wdata;
        CFG_MEASUREMENT_NOISE:  fcfg_r.r  <= cfg_wdata;
        CFG_INITIAL_COVARIANCE: fcfg_r.p0 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  cksb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_column     (in_column),
    .in_net_output (in_net_output),
    .height        (height_r),
    .q_count       (q_count),
    .push          (push)
  );

  cksb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .count (q_count)
  );

  cksb_back #(
    .COLUMN_COUNT (COLUMN_COUNT)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (fcfg_r),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_column_echo   (out_column_echo),
    .out_predicted_row (out_predicted_row),
    .out_corrected_row (out_corrected_row)
  );

  `CKSB_ASSERT_ALWAYS(a_q_no_overflow, q_count <= QCW'(QDEPTH), "queue overflow")
  `CKSB_ASSERT_IMPLY(a_pop_nonempty, pop, head.vld, "pop from empty queue")
  `CKSB_ASSERT_IMPLY(a_push_room, push.vld, q_count < QCW'(QDEPTH), "push into full queue")
  `CKSB_ASSERT_NEXT(a_reset_empty, !rst_n, q_count == '0 && !out_valid, "not empty after reset")

endmodule

// ===== design/cksb_front.sv =====
// ---------------------------------------------------------------------------
// cksb_front
// Accepts items, scales the network fraction into a Q10.6 measured row.
// ---------------------------------------------------------------------------
module cksb_front import cksb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [COL_W-1:0]  in_column,
  input  logic [FRAC_W-1:0] in_net_output,
  input  logic [HGT_W-1:0]  height,
  input  logic [QCW-1:0]    q_count,
  output cksb_qport_t       push
);

  logic                      f_vld_r;
  logic [COL_W-1:0]          f_col_r;
  logic [FRAC_W+HGT_W-1:0]   f_prod_r;
  logic [FRAC_W+HGT_W:0]     rnd;
  logic                      accept;

  // one slot for the product stage, so stop two short of full
  assign in_stall = q_count >= QCW'(QDEPTH - 2);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_col_r  <= in_column;
      f_prod_r <= in_net_output * height;
    end
  end

  always_comb begin
    rnd = {1'b0, f_prod_r} + (FRAC_W+HGT_W+1)'(512);
    push.vld      = f_vld_r;
    push.item.col = f_col_r;
    if (|rnd[FRAC_W+HGT_W:ROW_W+10]) begin
      push.item.z = '1;
    end else begin
      push.item.z = rnd[ROW_W+9:10];
    end
  end

endmodule

// ===== design/cksb_queue.sv =====
// ---------------------------------------------------------------------------
// cksb_queue
// Short FIFO between the front end and the filter pipeline.
// ---------------------------------------------------------------------------
module cksb_queue import cksb_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  cksb_qport_t    push,
  input  logic           pop,
  output cksb_qport_t    head,
  output logic [QCW-1:0] count
);

  cksb_item_t     mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QCW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.vld) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + QCW'(push.vld) - QCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      mem[wr_ptr_r] <= push.item;
    end
  end

  assign head.vld  = count_r != '0;
  assign head.item = mem[rd_ptr_r];
  assign count     = count_r;

endmodule

// ===== design/cksb_back.sv =====
// ---------------------------------------------------------------------------
// cksb_back
// Filter pipeline: state read, prior, pipelined gain divider, correction,
// state write-back and output register. Same-column items wait on hazard.
// ---------------------------------------------------------------------------
module cksb_back import cksb_pkg::*; #(
  parameter int COLUMN_COUNT = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cksb_filt_cfg_t   cfg,
  input  cksb_qport_t      head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [COL_W-1:0] out_column_echo,
  output logic [ROW_W-1:0] out_predicted_row,
  output logic [ROW_W-1:0] out_corrected_row
);

  localparam int AW  = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
  localparam int NST = DIV_STAGES + 1;
  localparam int L   = NST - 1;
  localparam logic [COV_W:0] ONE = 25'h1000000;

  logic [ROW_W-1:0]        est_mem [COLUMN_COUNT];
  logic [COV_W-1:0]        cov_mem [COLUMN_COUNT];
  logic [COLUMN_COUNT-1:0] seen_r;

  logic             adv, hazard, head_in;
  logic [AW-1:0]    rd_idx, wr_idx;

  // read stage
  logic             s1_vld_r, s1_in_r, s1_seen_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_z_r, rd_x_r;
  logic [COV_W-1:0] rd_p_r;
  logic [ROW_W-1:0] x_prev;
  logic [COV_W-1:0] p_prev, p_pri;
  logic [COV_W:0]   p_sum, s_sum;
  logic [2*COV_W:0] nmr;

  // divider stages
  logic             d_vld_r [NST];
  logic             d_in_r  [NST];
  logic [COL_W-1:0] d_col_r [NST];
  logic [ROW_W-1:0] d_z_r   [NST];
  logic [ROW_W-1:0] d_x_r   [NST];
  logic [COV_W-1:0] d_pp_r  [NST];
  logic [COV_W:0]   d_s_r   [NST];
  logic [COV_W:0]   d_rem_r [NST];
  logic [COV_W:0]   d_low_r [NST];
  logic [COV_W:0]   d_q_r   [NST];
  logic [COV_W:0]   d_rem_nxt [NST];
  logic             d_ge    [NST];

  // multiply stage
  logic [COV_W:0]         k;
  logic                   up;
  logic [ROW_W-1:0]       diff;
  logic                   m_vld_r, m_in_r, m_up_r;
  logic [COL_W-1:0]       m_col_r;
  logic [ROW_W-1:0]       m_x_r;
  logic [ROW_W+COV_W:0]   m_mag_r;
  logic [2*COV_W:0]       m_pprod_r;

  // finish
  logic [ROW_W:0]         adj;
  logic [ROW_W+1:0]       xn;
  logic [ROW_W-1:0]       x_new;
  logic [COV_W:0]         p_rnd;
  logic [COV_W-1:0]       p_post;

  logic             out_valid_r;
  logic [COL_W-1:0] out_col_r;
  logic [ROW_W-1:0] out_pred_r, out_corr_r;

  assign adv     = !out_valid_r || !out_stall;
  assign rd_idx  = AW'(head.item.col);
  assign wr_idx  = AW'(m_col_r);
  assign head_in = 32'(head.item.col) < COLUMN_COUNT;

  always_comb begin
    hazard = (s1_vld_r && s1_col_r == head.item.col) ||
             (m_vld_r && m_col_r == head.item.col);
    for (int i = 0; i < NST; i++) begin
      if (d_vld_r[i] && d_col_r[i] == head.item.col) begin
        hazard = 1'b1;
      end
    end
  end

  assign pop = adv && head.vld && !hazard;

  // ---- read stage ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_col_r  <= head.item.col;
      s1_z_r    <= head.item.z;
      s1_in_r   <= head_in;
      s1_seen_r <= head_in && seen_r[rd_idx];
      rd_x_r    <= est_mem[rd_idx];
      rd_p_r    <= cov_mem[rd_idx];
    end
  end

  always_comb begin
    x_prev = s1_seen_r ? rd_x_r : '0;
    p_prev = s1_seen_r ? rd_p_r : cfg.p0;
    p_sum  = {1'b0, p_prev} + {1'b0, cfg.q};
    p_pri  = p_sum[COV_W] ? '1 : p_sum[COV_W-1:0];
    s_sum  = {1'b0, p_pri} + {1'b0, cfg.r};
    nmr    = {1'b0, p_pri, 24'b0} + (2*COV_W+1)'(s_sum >> 1);
  end

  // ---- divider: one quotient bit per stage ----
  always_comb begin
    logic [COV_W+1:0] trial;
    for (int i = 0; i < NST; i++) begin
      trial        = {d_rem_r[i], d_low_r[i][COV_W]};
      d_ge[i]      = trial >= {1'b0, d_s_r[i]};
      d_rem_nxt[i] = d_ge[i] ? (COV_W+1)'(trial - {1'b0, d_s_r[i]}) : trial[COV_W:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) begin
        d_vld_r[i] <= 1'b0;
      end
    end else if (adv) begin
      d_vld_r[0] <= s1_vld_r;
      for (int i = 1; i < NST; i++) begin
        d_vld_r[i] <= d_vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_in_r[0]  <= s1_in_r;
      d_col_r[0] <= s1_col_r;
      d_z_r[0]   <= s1_z_r;
      d_x_r[0]   <= x_prev;
      d_pp_r[0]  <= p_pri;
      d_s_r[0]   <= s_sum;
      d_rem_r[0] <= {1'b0, nmr[2*COV_W:COV_W+1]};
      d_low_r[0] <= nmr[COV_W:0];
      d_q_r[0]   <= '0;
      for (int i = 1; i < NST; i++) begin
        d_in_r[i]  <= d_in_r[i-1];
        d_col_r[i] <= d_col_r[i-1];
        d_z_r[i]   <= d_z_r[i-1];
        d_x_r[i]   <= d_x_r[i-1];
        d_pp_r[i]  <= d_pp_r[i-1];
        d_s_r[i]   <= d_s_r[i-1];
        d_rem_r[i] <= d_rem_nxt[i-1];
        d_low_r[i] <= {d_low_r[i-1][COV_W-1:0], 1'b0};
        d_q_r[i]   <= {d_q_r[i-1][COV_W-1:0], d_ge[i-1]};
      end
    end
  end

  // ---- gain and products ----
  always_comb begin
    if (d_s_r[L] == '0) begin
      k = '0;
    end else if (d_q_r[L] > ONE) begin
      k = ONE;
    end else begin
      k = d_q_r[L];
    end
    up   = d_z_r[L] >= d_x_r[L];
    diff = up ? d_z_r[L] - d_x_r[L] : d_x_r[L] - d_z_r[L];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= d_vld_r[L];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_in_r    <= d_in_r[L];
      m_col_r   <= d_col_r[L];
      m_x_r     <= d_x_r[L];
      m_up_r    <= up;
      m_mag_r   <= diff * k;
      m_pprod_r <= (ONE - k) * d_pp_r[L];
    end
  end

  // ---- correction ----
  always_comb begin
    adj   = (ROW_W+1)'((m_mag_r + (ROW_W+COV_W+1)'(24'h800000)) >> 24);
    xn    = m_up_r ? {2'b0, m_x_r} + {1'b0, adj} : {2'b0, m_x_r} - {1'b0, adj};
    if (xn[ROW_W+1]) begin
      x_new = '0;
    end else if (xn[ROW_W]) begin
      x_new = '1;
    end else begin
      x_new = xn[ROW_W-1:0];
    end
    p_rnd  = (COV_W+1)'((m_pprod_r + (2*COV_W+1)'(24'h800000)) >> 24);
    p_post = p_rnd[COV_W] ? '1 : p_rnd[COV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv && m_vld_r && m_in_r) begin
      est_mem[wr_idx] <= x_new;
      cov_mem[wr_idx] <= p_post;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (adv && m_vld_r && m_in_r) begin
      seen_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && m_vld_r) begin
      out_col_r  <= m_col_r;
      out_pred_r <= m_x_r;
      out_corr_r <= x_new;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_column_echo   = out_col_r;
  assign out_predicted_row = out_pred_r;
  assign out_corrected_row = out_corr_r;

endmodule

// ===== bench/tb_column_kalman_smoother_bank.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_column_kalman_smoother_bank
// Self-checking bench for the column Kalman filter bank. A behavioral
// predictor keeps per-column estimate and covariance, computes the expected
// prior and corrected rows for each transfer, and a checker compares every
// result in order. Random gaps on both sides, long output hold-off, several
// register settings including extremes.
// ---------------------------------------------------------------------------
module tb_column_kalman_smoother_bank import cksb_pkg::*;;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] prior;
    logic [ROW_W-1:0] post;
  } row_pair_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [COL_W-1:0]     in_column;
  logic [FRAC_W-1:0]    in_net_output;
  logic                 out_valid;
  logic                 out_stall;
  logic [COL_W-1:0]     out_column_echo;
  logic [ROW_W-1:0]     out_predicted_row;
  logic [ROW_W-1:0]     out_corrected_row;

  column_kalman_smoother_bank u_dut (.*);

  // predictor state
  logic [HGT_W-1:0] height_r;
  logic [COV_W-1:0] q_r, r_r, p0_r;
  logic [ROW_W-1:0] est_mem [128];
  logic [COV_W-1:0] cov_mem [128];
  bit               seen_mem [128];

  row_pair_t rows_pending[$];
  int  mismatches;
  int  hold_cycles;
  int  out_wait;
  bit  bursty_out;
  longint cycle_cnt;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 64'd3000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic row_pair_t filter_update(logic [COL_W-1:0] col,
                                              logic [FRAC_W-1:0] frac);
    row_pair_t res;
    logic [63:0] z, ppri, s, k, mag, adj, ppost, xp;
    longint xn;
    xp = 0;
    ppri = p0_r;
    if (seen_mem[col]) begin
      xp = est_mem[col];
      ppri = cov_mem[col];
    end
    z = (64'(frac) * height_r + 512) >> 10;
    if (z > 64'hFFFF) z = 64'hFFFF;
    ppri = ppri + q_r;
    if (ppri > 64'hFFFFFF) ppri = 64'hFFFFFF;
    s = ppri + r_r;
    k = 0;
    if (s != 0) k = ((ppri << 24) + (s >> 1)) / s;
    if (k > 64'h1000000) k = 64'h1000000;
    if (z >= xp) begin
      mag = (z - xp) * k;
      adj = (mag + 64'h800000) >> 24;
      xn = longint'(xp) + longint'(adj);
    end else begin
      mag = (xp - z) * k;
      adj = (mag + 64'h800000) >> 24;
      xn = longint'(xp) - longint'(adj);
    end
    if (xn < 0) xn = 0;
    if (xn > 65535) xn = 65535;
    ppost = ((64'h1000000 - k) * ppri + 64'h800000) >> 24;
    if (ppost > 64'hFFFFFF) ppost = 64'hFFFFFF;
    est_mem[col] = xn[15:0];
    cov_mem[col] = ppost[23:0];
    seen_mem[col] = 1'b1;
    res.col = col;
    res.prior = xp[15:0];
    res.post = xn[15:0];
    return res;
  endfunction

  // result checker and output stall
  always @(posedge clk) begin
    row_pair_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (rows_pending.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result col %0d", out_column_echo);
      end else begin
        exp_r = rows_pending.pop_front();
        if (exp_r.col !== out_column_echo || exp_r.prior !== out_predicted_row ||
            exp_r.post !== out_corrected_row) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp col %0d prior %h post %h, got col %0d prior %h post %h",
                     exp_r.col, exp_r.prior, exp_r.post, out_column_echo,
                     out_predicted_row, out_corrected_row);
        end
      end
    end
  end

  always @(posedge clk) begin
    int w;
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (out_wait > 0) begin
      out_wait <= out_wait - 1;
      out_stall <= 1'b1;
    end else if (bursty_out && out_valid && !out_stall) begin
      w = $urandom_range(0, 19);
      out_wait <= (w > 0) ? w - 1 : 0;
      out_stall <= (w > 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic write_reg(cksb_cfg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_IMAGE_HEIGHT:       height_r = val[HGT_W-1:0];
      CFG_PROCESS_NOISE:      q_r = val;
      CFG_MEASUREMENT_NOISE:  r_r = val;
      CFG_INITIAL_COVARIANCE: p0_r = val;
      default: ;
    endcase
  endtask

  task automatic send_item(logic [COL_W-1:0] col, logic [FRAC_W-1:0] frac, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_column <= col;
    in_net_output <= frac;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rows_pending = {rows_pending, filter_update(col, frac)};
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (rows_pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_all(logic [CFG_W-1:0] h, logic [CFG_W-1:0] q,
                         logic [CFG_W-1:0] r, logic [CFG_W-1:0] p0);
    drain();
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_PROCESS_NOISE, q);
    write_reg(CFG_MEASUREMENT_NOISE, r);
    write_reg(CFG_INITIAL_COVARIANCE, p0);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed();
    send_item(7'd0, 16'h0000, 0);
    send_item(7'd127, 16'hFFFF, 0);
    send_item(7'd127, 16'hFFFF, 0);
    send_item(7'd0, 16'hFFFF, 1);
    send_item(7'd0, 16'h0000, 0);
    send_item(7'd64, 16'h8000, 0);
    send_item(7'd64, 16'h0001, 0);
    set_all(24'd1023, 24'hFFFFFF, 24'd1, 24'hFFFFFF);
    send_item(7'd5, 16'hFFFF, 0);
    send_item(7'd5, 16'h0000, 0);
    send_item(7'd6, 16'h5555, 0);
    set_all(24'd1, 24'd0, 24'hFFFFFF, 24'd0);
    send_item(7'd9, 16'hAAAA, 0);
    send_item(7'd9, 16'hFFFF, 0);
    // zero innovation variance: R written as zero via masking-free write
    set_all(24'd512, 24'd0, 24'd0, 24'd0);
    send_item(7'd100, 16'h1234, 0);
    send_item(7'd100, 16'hFEDC, 0);
    set_all(24'd360, 24'd167772, 24'd21810, 24'd1677722);
  endtask

  task automatic test_random(int n, bit gaps, bit hot);
    logic [COL_W-1:0] c;
    for (int i = 0; i < n; i++) begin
      c = hot ? 7'($urandom_range(0, 3)) : 7'($urandom);
      send_item(c, 16'($urandom), gaps ? ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19)) : 0);
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    test_random(60, 0, 0);
    drain();
  endtask

  task automatic test_config_sweep();
    set_all(24'($urandom_range(1, 1023)), 24'($urandom), 24'($urandom_range(1, 24'hFFFFFF)),
            24'($urandom));
    test_random(200, 1, 0);
    set_all(24'($urandom_range(1, 1023)), 24'($urandom_range(0, 2000)),
            24'($urandom_range(1, 2000)), 24'($urandom_range(0, 200000)));
    test_random(200, 1, 1);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = CFG_IMAGE_HEIGHT; cfg_wdata = '0;
    in_valid = 1'b0; in_column = '0; in_net_output = '0;
    out_stall = 1'b0; hold_cycles = 0; out_wait = 0; bursty_out = 1'b0;
    mismatches = 0; cycle_cnt = 0;
    height_r = 10'd360; q_r = 24'd167772; r_r = 24'd21810; p0_r = 24'd1677722;
    for (int i = 0; i < 128; i++) begin
      est_mem[i] = '0; cov_mem[i] = '0; seen_mem[i] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(150, 0, 1);
    bursty_out = 1'b1;
    test_random(300, 1, 0);
    test_backpressure();
    test_config_sweep();
    bursty_out = 1'b0;
    test_random(200, 0, 0);
    bursty_out = 1'b1;
    test_random(100, 1, 1);
    drain();
    if (mismatches == 0 && rows_pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
